>>> hdl/dcpr_pkg.sv
// ----------------------------------------------------------------------------
// dcpr_pkg
// Shared types and constants for the daisy chain position receiver.
// ----------------------------------------------------------------------------
package dcpr_pkg;

	// Protocol phases, as reported on the result channel.
	typedef enum logic [2:0] {
		PH_WAIT     = 3'd0,
		PH_TOGGLE   = 3'd1,
		PH_HS_A     = 3'd2,
		PH_HS_B     = 3'd3,
		PH_RECEIVE  = 3'd4,
		PH_DONE     = 3'd5,
		PH_RESTART  = 3'd6
	} phase_t;

	// Configuration register indexes.
	localparam logic REG_TOGGLE_TICKS  = 1'b0;
	localparam logic REG_RESTART_TICKS = 1'b1;

	localparam logic [7:0] TOGGLE_TICKS_RST  = 8'd3;
	localparam logic [7:0] RESTART_TICKS_RST = 8'd30;
	localparam logic [3:0] BITS_PER_XFER     = 4'd8;
	localparam logic [7:0] X_MASK            = 8'h07;
	localparam logic [7:0] Y_MASK            = 8'h78;

	// One result beat.
	typedef struct packed {
		logic [2:0] phase;
		logic       below_drive;
		logic       left_drive;
		logic       active_released;
		logic [6:0] position;
		logic       position_valid;
		logic       restarted;
	} result_t;

endpackage

>>> hdl/dcpr_if.sv
// ----------------------------------------------------------------------------
// dcpr_if
// Channel interfaces: pin samples in, results out, configuration writes.
// ----------------------------------------------------------------------------
interface dcpr_in_if;
	logic valid;
	logic ready;
	logic clk_level;
	logic data_level;
	logic below_level;
	logic left_level;
	logic tick;

	modport source (output valid, clk_level, data_level, below_level, left_level, tick,
		input ready);
	modport sink (input valid, clk_level, data_level, below_level, left_level, tick,
		output ready);
endinterface

interface dcpr_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] phase;
	logic       below_drive;
	logic       left_drive;
	logic       active_released;
	logic [6:0] position;
	logic       position_valid;
	logic       restarted;

	modport source (output valid, phase, below_drive, left_drive, active_released,
		position, position_valid, restarted, input ready);
	modport sink (input valid, phase, below_drive, left_drive, active_released,
		position, position_valid, restarted, output ready);
endinterface

interface dcpr_cfg_if;
	logic       valid;
	logic       ready;
	logic       index;
	logic [7:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hdl/dcpr_skid.sv
// ----------------------------------------------------------------------------
// dcpr_skid
// Two-entry result buffer: an output register backed by a skid register.
// ----------------------------------------------------------------------------
module dcpr_skid
	import dcpr_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push_valid,
	output logic    push_ready,
	input  result_t push_data,
	dcpr_out_if.source result
);

	result_t out_q;
	result_t skid_q;
	logic    out_valid_q;
	logic    skid_valid_q;
	logic    out_free;
	logic    push_fire;

	// The input side only stalls when both entries are full.
	assign push_ready = !skid_valid_q;
	assign push_fire  = push_valid && push_ready;
	assign out_free   = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q  <= skid_valid_q || push_fire;
				skid_valid_q <= 1'b0;
			end else if (push_fire) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (push_fire) begin
				out_q <= push_data;
			end
		end else if (push_fire) begin
			skid_q <= push_data;
		end
	end

	assign result.valid           = out_valid_q;
	assign result.phase           = out_q.phase;
	assign result.below_drive     = out_q.below_drive;
	assign result.left_drive      = out_q.left_drive;
	assign result.active_released = out_q.active_released;
	assign result.position        = out_q.position;
	assign result.position_valid  = out_q.position_valid;
	assign result.restarted       = out_q.restarted;

endmodule

>>> hdl/daisy_chain_position_receiver.sv
// ----------------------------------------------------------------------------
// daisy_chain_position_receiver
// Receiving side of the tile-to-tile position handshake.
// ----------------------------------------------------------------------------
// Each beat on the sample channel is one sampling of the serial clock, serial
// data and the two select pins, plus a flag saying whether a time tick has
// elapsed. The block compares each sample with the previous one to find
// edges, walks the handshake (wait, toggling the below and left selects,
// two handshake phases, receiving eight bits MSB first, done, and a restart
// wait after a protocol error) and returns exactly one result beat per
// sample, telling the caller how to drive the select lines, which phase the
// block is in, and once a transfer has completed the 7-bit position (bits 2..0
// x, bits 6..3 y). The whole state update is shallow combinational logic,
// so a sample is accepted on every clock; the result is registered and backed
// by a skid register, so the sample side keeps moving while one result beat
// waits and stalls only when two are held. Configuration writes (toggle and
// restart tick counts; a count of zero behaves as one) are accepted on every
// cycle and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module daisy_chain_position_receiver
	import dcpr_pkg::*;
(
	input logic clk,
	input logic arst_n,
	dcpr_in_if.sink     sample,
	dcpr_out_if.source  result,
	dcpr_cfg_if.sink    cfg
);

	// Configuration registers.
	logic [7:0] toggle_ticks_q;
	logic [7:0] restart_ticks_q;

	// Protocol state.
	phase_t     phase_q,      phase_d;
	logic [3:0] prev_pins_q;
	logic       side_left_q,  side_left_d;
	logic       drive_high_q, drive_high_d;
	logic [7:0] timer_q,      timer_d;
	logic [7:0] shift_q,      shift_d;
	logic [3:0] bits_left_q,  bits_left_d;
	logic       from_left_q,  from_left_d;
	logic       from_below_q, from_below_d;
	logic [6:0] addr_q,       addr_d;

	logic [3:0] cur_pins;
	logic [3:0] changed;
	logic       clk_edge;
	logic       clk_rise;
	logic       clk_fall;
	logic       data_bit;
	logic       sel_level;
	logic       restarted;
	logic [7:0] toggle_reload;
	logic [7:0] restart_reload;
	logic [3:0] bit_idx;
	logic [7:0] x_sum;
	logic [7:0] y_sum;
	logic       xfer_end;
	logic       push_ready;
	logic       accept;
	result_t    res;

	assign cfg.ready    = 1'b1;
	assign sample.ready = push_ready;
	assign accept       = sample.valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_ticks_q  <= TOGGLE_TICKS_RST;
			restart_ticks_q <= RESTART_TICKS_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_TOGGLE_TICKS:  toggle_ticks_q  <= cfg.data;
				REG_RESTART_TICKS: restart_ticks_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Pin order in the stored sample: clock, data, below, left from bit 0 up.
	assign cur_pins  = {sample.left_level, sample.below_level, sample.data_level,
		sample.clk_level};
	assign changed   = cur_pins ^ prev_pins_q;
	assign clk_edge  = changed[0];
	assign clk_rise  = clk_edge && !prev_pins_q[0];
	assign clk_fall  = clk_edge && prev_pins_q[0];
	assign data_bit  = cur_pins[1];
	assign sel_level = side_left_q ? cur_pins[3] : cur_pins[2];

	// A programmed count of zero behaves as one.
	assign toggle_reload  = (toggle_ticks_q == 8'd0) ? 8'd1 : toggle_ticks_q;
	assign restart_reload = (restart_ticks_q == 8'd0) ? 8'd1 : restart_ticks_q;

	assign bit_idx = bits_left_q - 4'd1;
	assign x_sum   = shift_q + {7'd0, from_left_q};
	assign y_sum   = shift_q + {4'd0, from_below_q, 3'd0};

	always_comb begin
		phase_d      = phase_q;
		side_left_d  = side_left_q;
		drive_high_d = drive_high_q;
		timer_d      = timer_q;
		shift_d      = shift_q;
		bits_left_d  = bits_left_q;
		from_left_d  = from_left_q;
		from_below_d = from_below_q;
		addr_d       = addr_q;
		restarted    = 1'b0;
		xfer_end     = 1'b0;

		unique case (phase_q)
			PH_TOGGLE: begin
				// The sender answers with a rising clock while data is high.
				if (clk_rise && data_bit) begin
					phase_d = PH_HS_A;
				end else if (clk_edge) begin
					phase_d   = PH_RESTART;
					timer_d   = restart_reload;
					restarted = 1'b1;
				end else if (data_bit) begin
					phase_d = PH_WAIT;
				end else if (sample.tick) begin
					if (timer_q > 8'd1) begin
						timer_d = timer_q - 8'd1;
					end else begin
						// Alternate high and low, swapping sides at each new pulse.
						if (drive_high_q) begin
							drive_high_d = 1'b0;
						end else begin
							side_left_d  = !side_left_q;
							drive_high_d = 1'b1;
						end
						timer_d = toggle_reload;
					end
				end
			end
			PH_HS_A: begin
				if (clk_fall) begin
					phase_d = PH_HS_B;
				end else if (clk_edge) begin
					phase_d   = PH_RESTART;
					timer_d   = restart_reload;
					restarted = 1'b1;
				end
			end
			PH_HS_B: begin
				if (clk_rise && !data_bit && !sel_level) begin
					phase_d      = PH_RECEIVE;
					shift_d      = 8'd0;
					bits_left_d  = BITS_PER_XFER;
					from_left_d  = 1'b0;
					from_below_d = 1'b0;
				end else if (clk_edge) begin
					phase_d   = PH_RESTART;
					timer_d   = restart_reload;
					restarted = 1'b1;
				end
			end
			PH_RECEIVE: begin
				// Below select wins over left, and either wins over the clock.
				priority if (changed[2] && !from_left_q) begin
					if (prev_pins_q[2]) begin
						xfer_end = 1'b1;
					end else begin
						from_below_d = 1'b1;
					end
				end else if (changed[3] && !from_below_q) begin
					if (prev_pins_q[3]) begin
						xfer_end = 1'b1;
					end else begin
						from_left_d = 1'b1;
					end
				end else if (clk_rise) begin
					if (bits_left_q != 4'd0 && bits_left_q <= BITS_PER_XFER) begin
						bits_left_d = bit_idx;
						shift_d[bit_idx[2:0]] = shift_q[bit_idx[2:0]] | data_bit;
					end
				end else begin
					// No select or clock edge of interest: the transfer holds.
				end
				if (xfer_end) begin
					addr_d      = 7'((x_sum & X_MASK) | (y_sum & Y_MASK));
					bits_left_d = BITS_PER_XFER;
					phase_d     = PH_DONE;
				end
			end
			PH_DONE: begin
			end
			PH_RESTART: begin
				if (sample.tick) begin
					if (timer_q > 8'd1) begin
						timer_d = timer_q - 8'd1;
					end else begin
						timer_d = 8'd0;
						phase_d = PH_WAIT;
					end
				end
			end
			default: begin
				// Waiting, and the unused phase code: start once clock and data are low.
				phase_d = PH_WAIT;
				if (!cur_pins[0] && !data_bit) begin
					phase_d      = PH_TOGGLE;
					side_left_d  = 1'b0;
					drive_high_d = 1'b1;
					timer_d      = toggle_reload;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_WAIT;
			prev_pins_q  <= 4'd0;
			side_left_q  <= 1'b0;
			drive_high_q <= 1'b0;
			timer_q      <= 8'd0;
			shift_q      <= 8'd0;
			bits_left_q  <= BITS_PER_XFER;
			from_left_q  <= 1'b0;
			from_below_q <= 1'b0;
			addr_q       <= 7'd0;
		end else if (accept) begin
			phase_q      <= phase_d;
			prev_pins_q  <= cur_pins;
			side_left_q  <= side_left_d;
			drive_high_q <= drive_high_d;
			timer_q      <= timer_d;
			shift_q      <= shift_d;
			bits_left_q  <= bits_left_d;
			from_left_q  <= from_left_d;
			from_below_q <= from_below_d;
			addr_q       <= addr_d;
		end
	end

	// Result fields follow the state after this sample. A released select
	// line reads high through its pull-up.
	always_comb begin
		res                 = '0;
		res.phase           = phase_d;
		res.position        = addr_d;
		res.position_valid  = (phase_d == PH_DONE);
		res.restarted       = restarted;
		if (phase_d == PH_TOGGLE) begin
			res.left_drive  = side_left_d && drive_high_d;
			res.below_drive = !side_left_d && drive_high_d;
		end else if (phase_d == PH_HS_B || phase_d == PH_RECEIVE) begin
			res.active_released = 1'b1;
			res.left_drive      = side_left_d;
			res.below_drive     = !side_left_d;
		end
	end

	dcpr_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (sample.valid),
		.push_ready (push_ready),
		.push_data  (res),
		.result     (result)
	);

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the daisy chain position receiver.
// ----------------------------------------------------------------------------
// Pin samples go in through the sample channel. A behavioural copy of the
// receiver, kept in this bench, works out the status beat that each accepted
// sample must produce. Beats are checked field by field on the result channel.
// A short table of hand-picked samples comes first. It is followed by random
// handshake traffic under several tick settings, and the run ends with one
// complete position transfer.
// ----------------------------------------------------------------------------
module tb;
	import dcpr_pkg::*;

	// The run stops here at the latest. That is several times the slowest
	// legal run, in which every sample and every beat waits out the
	// longest idle draw.
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SEG_SAMPLES   = 300;
	localparam int SEGMENTS      = 6;
	localparam int FINALE_BUDGET = 4000;
	localparam int OPENING_ROWS  = 25;
	localparam int PRINT_CAP     = 40;

	// One pin sample, in the order in which the table below spells it out.
	typedef struct packed {
		logic clk_level;
		logic data_level;
		logic below_level;
		logic left_level;
		logic tick;
	} pin_sample_t;

	typedef enum logic {ROW_SAMPLE, ROW_WRITE} row_kind_t;

	// A row either writes a register or sends a sample. A sample row may carry
	// a status typed in by hand. When it does, that status is expected in
	// place of the predicted one.
	typedef struct packed {
		row_kind_t   kind;
		pin_sample_t pins;
		logic        typed;
		result_t     want;
		logic        reg_index;
		logic [7:0]  reg_value;
	} stim_row_t;

	localparam result_t IDLE_STATUS         = '{PH_WAIT, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0};
	localparam result_t TOGGLE_BELOW_STATUS = '{PH_TOGGLE, 1'b1, 1'b0, 1'b0, 7'd0, 1'b0, 1'b0};
	localparam result_t RESTART_STATUS      = '{PH_RESTART, 1'b0, 1'b0, 1'b0, 7'd0, 1'b0, 1'b1};

	// Pins are written as 5'b<clk><data><below><left><tick>.
	stim_row_t opening_rows [OPENING_ROWS] = '{
		// Zero restart count, which must behave as one, so that restarts stay short.
		'{ROW_WRITE,  5'b00000, 1'b0, '0, REG_RESTART_TICKS, 8'd0},
		// Clock and data low: toggling starts on the below select.
		'{ROW_SAMPLE, 5'b00000, 1'b1, TOGGLE_BELOW_STATUS, REG_TOGGLE_TICKS, 8'd0},
		// Ticks at the reset toggle count walk the pulse low, then over to left.
		'{ROW_SAMPLE, 5'b00001, 1'b0, '0, REG_TOGGLE_TICKS, 8'd0},
		'{ROW_SAMPLE, 5'b00001, 1'b0, '0, REG_TOGGLE_TICKS, 8'd0},
		'{ROW_SAMPLE, 5'b00001, 1'b0, '0, REG_TOGGLE_TICKS, 8'd0},
		'{ROW_SAMPLE, 5'b00101, 1'b0, '0, REG_TOGGLE_TICKS, 8'd0},
		'{ROW_SAMPLE, 5'b00011, 1'b0, '0, REG_TOGGLE_TICKS, 8'd0},
		'{ROW_SAMPLE, 5'b00001, 1'b0, '0, REG_TOGGLE_TICKS, 8'd0},
		// Data rising with no clock edge drops back to wait.
		'{ROW_SAMPLE, 5'b01000, 1'b1, IDLE_STATUS, REG_TOGGLE_TICKS, 8'd0},
		'{ROW_SAMPLE, 5'b00000, 1'b1, TOGGLE_BELOW_STATUS, REG_TOGGLE_TICKS, 8'd0},
		// A clock rise with data low does not fit while toggling.
		'{ROW_SAMPLE, 5'b10000, 1'b1, RESTART_STATUS, REG_TOGGLE_TICKS, 8'd0},
		'{ROW_SAMPLE, 5'b10000, 1'b0, '0, REG_TOGGLE_TICKS, 8'd0},
		'{ROW_SAMPLE, 5'b01111, 1'b1, IDLE_STATUS, REG_TOGGLE_TICKS, 8'd0},
		// A clean answer: rise with data high, fall, then a rise with data high,
		// which is not allowed in the second handshake phase.
		'{ROW_SAMPLE, 5'b00110, 1'b0, '0, REG_TOGGLE_TICKS, 8'd0},
		'{ROW_SAMPLE, 5'b11001, 1'b0, '0, REG_TOGGLE_TICKS, 8'd0},
		'{ROW_SAMPLE, 5'b10111, 1'b0, '0, REG_TOGGLE_TICKS, 8'd0},
		'{ROW_SAMPLE, 5'b00000, 1'b0, '0, REG_TOGGLE_TICKS, 8'd0},
		'{ROW_SAMPLE, 5'b01001, 1'b0, '0, REG_TOGGLE_TICKS, 8'd0},
		'{ROW_SAMPLE, 5'b11000, 1'b0, '0, REG_TOGGLE_TICKS, 8'd0},
		// Largest toggle count, written while the restart wait is running.
		'{ROW_WRITE,  5'b00000, 1'b0, '0, REG_TOGGLE_TICKS, 8'd255},
		'{ROW_SAMPLE, 5'b11111, 1'b1, IDLE_STATUS, REG_TOGGLE_TICKS, 8'd0},
		// Second handshake again, now broken by the active select being high.
		'{ROW_SAMPLE, 5'b00000, 1'b0, '0, REG_TOGGLE_TICKS, 8'd0},
		'{ROW_SAMPLE, 5'b11000, 1'b0, '0, REG_TOGGLE_TICKS, 8'd0},
		'{ROW_SAMPLE, 5'b00000, 1'b0, '0, REG_TOGGLE_TICKS, 8'd0},
		'{ROW_SAMPLE, 5'b10100, 1'b0, '0, REG_TOGGLE_TICKS, 8'd0}
	};

	// Tick settings for the random segments. The fifth is drawn at random.
	logic [7:0] seg_toggle  [SEGMENTS] = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd0, 8'd3};
	logic [7:0] seg_restart [SEGMENTS] = '{8'd1, 8'd255, 8'd7, 8'd0, 8'd0, 8'd30};

	logic clk;
	logic arst_n;

	dcpr_in_if  sample_ch ();
	dcpr_out_if result_ch ();
	dcpr_cfg_if cfg_ch ();

	daisy_chain_position_receiver dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// ------------------------------------------------------------------------
	// Receiver state as this bench sees it, plus the register copies.
	// ------------------------------------------------------------------------
	phase_t     rx_phase    = PH_WAIT;
	logic [3:0] last_pins   = 4'd0;      // bit 0 clock, 1 data, 2 below, 3 left
	logic       on_left     = 1'b0;
	logic [7:0] tick_count  = 8'd0;
	logic [7:0] rx_byte     = 8'd0;
	logic [3:0] bits_to_go  = BITS_PER_XFER;
	logic       via_left    = 1'b0;
	logic       via_below   = 1'b0;
	logic [6:0] rx_position = 7'd0;
	logic       pulse_high  = 1'b0;
	logic [7:0] toggle_cfg  = TOGGLE_TICKS_RST;
	logic [7:0] restart_cfg = RESTART_TICKS_RST;

	// Status beats still owed by the block, oldest first.
	result_t status_q [$];

	int  mismatches     = 0;
	int  beats_checked  = 0;
	int  samples_sent   = 0;
	int  settings_used  = 0;
	int  restarts_seen  = 0;
	int  cycles         = 0;
	logic done_seen     = 1'b0;
	logic [6:0] last_position = 7'd0;
	logic quiet_tx      = 1'b0;
	logic quiet_rx      = 1'b0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// A tick count of zero behaves as one.
	function automatic logic [7:0] floor_one(input logic [7:0] v);
		return (v == 8'd0) ? 8'd1 : v;
	endfunction

	// Moves the receiver state on by one sample and returns its status beat.
	task automatic advance_receiver(input pin_sample_t p, output result_t r);
		logic [3:0] cur;
		logic [3:0] changed;
		logic       clk_edge;
		logic       clk_rise;
		logic       clk_fall;
		logic       data;
		logic       sel;
		logic       restart;
		logic       finish_xfer;
		logic [7:0] sum_x;
		logic [7:0] sum_y;

		cur      = {p.left_level, p.below_level, p.data_level, p.clk_level};
		changed  = cur ^ last_pins;
		clk_edge = changed[0];
		clk_rise = clk_edge && !last_pins[0];
		clk_fall = clk_edge && last_pins[0];
		data     = cur[1];
		sel      = on_left ? cur[3] : cur[2];
		restart  = 1'b0;
		finish_xfer = 1'b0;

		case (rx_phase)
			PH_TOGGLE: begin
				if (clk_rise && data) begin
					rx_phase = PH_HS_A;
				end else if (clk_edge) begin
					restart = 1'b1;
				end else if (data) begin
					rx_phase = PH_WAIT;
				end else if (p.tick) begin
					if (tick_count > 8'd1) begin
						tick_count--;
					end else begin
						// A high pulse is followed by a low one. After the
						// low one the pulse moves to the other select.
						if (pulse_high) begin
							pulse_high = 1'b0;
						end else begin
							on_left    = !on_left;
							pulse_high = 1'b1;
						end
						tick_count = floor_one(toggle_cfg);
					end
				end
			end
			PH_HS_A: begin
				if (clk_fall)
					rx_phase = PH_HS_B;
				else if (clk_edge)
					restart = 1'b1;
			end
			PH_HS_B: begin
				if (clk_rise && !data && !sel) begin
					rx_phase   = PH_RECEIVE;
					rx_byte    = 8'd0;
					bits_to_go = BITS_PER_XFER;
					via_left   = 1'b0;
					via_below  = 1'b0;
				end else if (clk_edge) begin
					restart = 1'b1;
				end
			end
			PH_RECEIVE: begin
				// Below is looked at first. Once one side has framed the
				// transfer, the other select is ignored.
				if (changed[2] && !via_left) begin
					if (last_pins[2])
						finish_xfer = 1'b1;
					else
						via_below = 1'b1;
				end else if (changed[3] && !via_below) begin
					if (last_pins[3])
						finish_xfer = 1'b1;
					else
						via_left = 1'b1;
				end else if (clk_rise && bits_to_go != 4'd0 && bits_to_go <= BITS_PER_XFER) begin
					bits_to_go--;
					rx_byte[bits_to_go[2:0]] = rx_byte[bits_to_go[2:0]] | data;
				end
				if (finish_xfer) begin
					sum_x       = rx_byte + {7'd0, via_left};
					sum_y       = rx_byte + {4'd0, via_below, 3'd0};
					rx_position = 7'((sum_x & X_MASK) | (sum_y & Y_MASK));
					bits_to_go  = BITS_PER_XFER;
					rx_phase    = PH_DONE;
				end
			end
			PH_DONE: begin
			end
			PH_RESTART: begin
				if (p.tick) begin
					if (tick_count > 8'd1) begin
						tick_count--;
					end else begin
						tick_count = 8'd0;
						rx_phase   = PH_WAIT;
					end
				end
			end
			default: begin
				rx_phase = PH_WAIT;
				if (!cur[0] && !data) begin
					rx_phase   = PH_TOGGLE;
					on_left    = 1'b0;
					pulse_high = 1'b1;
					tick_count = floor_one(toggle_cfg);
				end
			end
		endcase

		if (restart) begin
			rx_phase   = PH_RESTART;
			tick_count = floor_one(restart_cfg);
		end
		last_pins = cur;

		r = '0;
		r.phase = rx_phase;
		if (rx_phase == PH_TOGGLE) begin
			r.left_drive  = on_left && pulse_high;
			r.below_drive = !on_left && pulse_high;
		end else if (rx_phase == PH_HS_B || rx_phase == PH_RECEIVE) begin
			// The active select is released and reads back its pull-up level.
			r.active_released = 1'b1;
			r.left_drive      = on_left;
			r.below_drive     = !on_left;
		end
		r.position       = rx_position;
		r.position_valid = (rx_phase == PH_DONE);
		r.restarted      = restart;
	endtask

	// Picks the next sample from the receiver's current phase. Most samples
	// move the handshake along. A few are plain noise. Outside the final
	// transfer run the block is kept out of receiving, because a finished transfer
	// holds until reset.
	function automatic pin_sample_t next_pins(input logic finale);
		pin_sample_t p;
		int          roll;

		p    = 5'($urandom);
		roll = $urandom_range(0, 31);
		if (rx_phase == PH_RECEIVE || roll >= 3) begin
			case (rx_phase)
				PH_WAIT: begin
					p.clk_level  = 1'b0;
					p.data_level = 1'b0;
				end
				PH_TOGGLE: begin
					roll = $urandom_range(0, 31);
					p.clk_level  = 1'b0;
					p.data_level = 1'b0;
					if (roll == 0) begin
						p.data_level = 1'b1;
					end else if (roll == 1) begin
						p.clk_level = 1'b1;
					end else if (roll <= 3) begin
						p.clk_level  = 1'b1;
						p.data_level = 1'b1;
					end
				end
				PH_HS_A: p.clk_level = ($urandom_range(0, 3) != 0);
				PH_HS_B: begin
					if ($urandom_range(0, 3) == 0) begin
						p.clk_level = 1'b1;
						if (finale) begin
							p.data_level = ($urandom_range(0, 3) == 0);
							if ($urandom_range(0, 3) != 0) begin
								if (on_left)
									p.left_level = 1'b0;
								else
									p.below_level = 1'b0;
							end
						end
					end else begin
						p.clk_level = 1'b0;
					end
				end
				PH_RESTART: p.tick = ($urandom_range(0, 3) != 0);
				PH_RECEIVE: begin
					// Mostly clock toggles with random data. Now and then a
					// select moves, which frames or ends the transfer.
					p.clk_level   = last_pins[0];
					p.below_level = last_pins[2];
					p.left_level  = last_pins[3];
					roll = $urandom_range(0, 24);
					if (roll == 0)
						p.below_level = !p.below_level;
					else if (roll == 1)
						p.left_level = !p.left_level;
					else if (roll < 18)
						p.clk_level = !p.clk_level;
				end
				default: begin
				end
			endcase
		end
		if (!finale && rx_phase == PH_HS_B && !last_pins[0] && p.clk_level && !p.data_level &&
			!(on_left ? p.left_level : p.below_level))
			p.data_level = 1'b1;
		return p;
	endfunction

	// Holds the sample channel low until every owed beat has come back.
	task automatic drain_results();
		sample_ch.valid <= 1'b0;
		while (status_q.size() != 0)
			@(posedge clk);
	endtask

	// Sends one sample after a random gap. On acceptance, the beat that the
	// sample must produce is queued.
	task automatic send_pins(input pin_sample_t p, input logic typed, input result_t want);
		int      gap;
		result_t r;

		gap = quiet_tx ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid       <= 1'b1;
		sample_ch.clk_level   <= p.clk_level;
		sample_ch.data_level  <= p.data_level;
		sample_ch.below_level <= p.below_level;
		sample_ch.left_level  <= p.left_level;
		sample_ch.tick        <= p.tick;
		do @(posedge clk); while (!sample_ch.ready);
		advance_receiver(p, r);
		status_q.push_back(typed ? want : r);
		samples_sent++;
	endtask

	// Register write, issued only once the block owes nothing. With hold set,
	// valid stays high so that a second write can follow in the next beat.
	task automatic write_reg(input logic idx, input logic [7:0] val, input logic hold);
		drain_results();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		if (!hold)
			cfg_ch.valid <= 1'b0;
		if (idx == REG_TOGGLE_TICKS)
			toggle_cfg = val;
		else
			restart_cfg = val;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("tb: beat %0d, %s: got %0d, expected %0d", beats_checked, what, got, want);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int          seg;
		int          n;
		logic [7:0]  tog;
		logic [7:0]  rst;

		arst_n                = 1'b0;
		sample_ch.valid       = 1'b0;
		sample_ch.clk_level   = 1'b0;
		sample_ch.data_level  = 1'b0;
		sample_ch.below_level = 1'b0;
		sample_ch.left_level  = 1'b0;
		sample_ch.tick        = 1'b0;
		cfg_ch.valid          = 1'b0;
		cfg_ch.index          = REG_TOGGLE_TICKS;
		cfg_ch.data           = 8'd0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Hand-picked opening. It starts at the reset tick counts.
		for (n = 0; n < OPENING_ROWS; n++) begin
			if (opening_rows[n].kind == ROW_WRITE) begin
				write_reg(opening_rows[n].reg_index, opening_rows[n].reg_value, 1'b0);
				settings_used++;
			end else begin
				send_pins(opening_rows[n].pins, opening_rows[n].typed, opening_rows[n].want);
			end
		end

		// Random handshake traffic. Each segment runs at its own tick counts.
		for (seg = 0; seg < SEGMENTS; seg++) begin
			tog = (seg == 4) ? 8'($urandom) : seg_toggle[seg];
			rst = (seg == 4) ? 8'($urandom) : seg_restart[seg];
			write_reg(REG_TOGGLE_TICKS, tog, 1'b1);
			write_reg(REG_RESTART_TICKS, rst, 1'b0);
			settings_used++;
			for (n = 0; n < SEG_SAMPLES; n++) begin
				if (n % 40 == 0)
					quiet_tx = ($urandom_range(0, 3) == 0);
				// Once, the sender holds off until the block owes nothing.
				if (seg == 0 && n == 150)
					drain_results();
				send_pins(next_pins(1'b0), 1'b0, '0);
			end
		end

		// Let one transfer through to the end, then prod the finished block.
		n = 0;
		while (rx_phase != PH_DONE && n < FINALE_BUDGET) begin
			send_pins(next_pins(1'b1), 1'b0, '0);
			n++;
		end
		for (n = 0; n < 20; n++)
			send_pins(next_pins(1'b1), 1'b0, '0);

		drain_results();
		repeat (8) @(posedge clk);

		$display("tb: %0d samples under %0d tick settings, %0d status beats checked",
			samples_sent, settings_used, beats_checked);
		$display("tb: %0d protocol restarts seen, transfer %s, position %0d",
			restarts_seen, done_seen ? "completed" : "not completed", last_position);
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

	// ------------------------------------------------------------------------
	// Result side: random stalls, with quiet stretches where ready stays high.
	// ------------------------------------------------------------------------
	initial begin
		int stall;
		int taken;

		result_ch.ready = 1'b0;
		taken = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (taken % 40 == 0)
				quiet_rx = ($urandom_range(0, 3) == 0);
			stall = quiet_rx ? 0 : $urandom_range(0, 6);
			if (stall != 0) begin
				result_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			taken++;
		end
	end

	// Every accepted beat is held against the oldest owed status.
	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (status_q.size() == 0) begin
				report_mismatch("beat with nothing owed, phase", result_ch.phase, 0);
			end else begin
				result_t want;
				want = status_q.pop_front();
				if (result_ch.phase != want.phase)
					report_mismatch("phase", result_ch.phase, want.phase);
				if (result_ch.below_drive != want.below_drive)
					report_mismatch("below_drive", result_ch.below_drive, want.below_drive);
				if (result_ch.left_drive != want.left_drive)
					report_mismatch("left_drive", result_ch.left_drive, want.left_drive);
				if (result_ch.active_released != want.active_released)
					report_mismatch("active_released", result_ch.active_released,
						want.active_released);
				if (result_ch.position != want.position)
					report_mismatch("position", result_ch.position, want.position);
				if (result_ch.position_valid != want.position_valid)
					report_mismatch("position_valid", result_ch.position_valid,
						want.position_valid);
				if (result_ch.restarted != want.restarted)
					report_mismatch("restarted", result_ch.restarted, want.restarted);
			end
			beats_checked++;
			if (result_ch.restarted)
				restarts_seen++;
			if (result_ch.position_valid) begin
				done_seen     <= 1'b1;
				last_position <= result_ch.position;
			end
		end
	end

	// Watchdog, in case a handshake never completes.
	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

endmodule

>>> filelist.f
hdl/dcpr_pkg.sv
hdl/dcpr_if.sv
hdl/dcpr_skid.sv
hdl/daisy_chain_position_receiver.sv
test/tb.sv
